// ===== rtl/pra_pkg.sv =====
// Shared types and constants for the physical region allocator.
// Used by pra_ctrl, pra_datapath and the top level.
package pra_pkg;

	localparam logic [63:0] CEILING_RESET = 64'h0000_0001_0000_0000;

	typedef enum logic [1:0] {
		FN_CREATE = 2'd0,
		FN_ANY    = 2'd1,
		FN_BASE   = 2'd2,
		FN_READ   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_OVERLAP = 3'd1,
		ST_NOFIT   = 3'd2,
		ST_NOTFREE = 3'd3,
		ST_FULL    = 3'd4,
		ST_BADARG  = 3'd5
	} st_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAP,
		OP_UP_INIT,
		OP_UP_STEP,
		OP_DN_INIT,
		OP_DN_STEP,
		OP_COMMIT,
		OP_FIND,
		OP_SHIFT,
		OP_MERGE,
		OP_INS_POST,
		OP_RD_IDX,
		OP_RES_ERR,
		OP_RES_OK,
		OP_RES_READ
	} op_t;

	typedef struct packed {
		func_t       func;
		logic [63:0] base;
		logic [63:0] size;
		logic [3:0]  region_type;
		logic [7:0]  entry_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] address;
		logic [63:0] out_size;
		logic [3:0]  out_type;
	} out_item_t;

	typedef struct packed {
		op_t op;
		st_t st;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  bad;
		logic  up_hit;
		logic  up_done;
		logic  dn_hit;
		logic  dn_done;
		logic  find_hit;
		logic  sh_done;
		logic  mg_done;
		logic  kind_used;
		logic  exact;
		logic  full1;
		logic  full_base;
		logic  pre;
		logic  post;
		logic  out_free;
	} stat_t;

endpackage

// ===== rtl/pra_datapath.sv =====
// Datapath: region table memory, request registers, scan pointers and result register.
// Depends on pra_pkg; driven by commands from pra_ctrl.
module pra_datapath import pra_pkg::*; #(
	parameter int MAX_REGIONS = 256,
	parameter int PAGE_SHIFT  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    in_item,
	input  logic        cfg_wen,
	input  logic [63:0] cfg_wdata,
	input  logic        out_stall,
	output logic        out_valid,
	output out_item_t   out_item,
	input  cmd_t        cmd,
	output stat_t       stat
);

	localparam int IW = $clog2(MAX_REGIONS);
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam int XW = (CW > 8) ? CW : 8;
	localparam int PW = 64 - PAGE_SHIFT;
	localparam logic [63:0] PG_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

	typedef struct packed {
		logic [PW-1:0] s;
		logic [PW-1:0] l;
		logic [3:0]    k;
	} ent_t;

	ent_t mem [MAX_REGIONS];
	ent_t rd_q;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	ent_t          wr_data;

	logic [63:0]   ceiling_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] i_q;
	logic          pv_s1;
	logic [IW-1:0] pidx_s1;
	logic          first_q;
	logic          out_valid_q;
	out_item_t     out_q;

	func_t         func_q;
	logic [PW-1:0] s_q;
	logic [PW-1:0] l_q;
	logic [PW-1:0] need_q;
	logic [3:0]    kind_q;
	logic [IW-1:0] idx_q;
	logic [63:0]   base_q;
	logic          bad_q;
	logic [IW-1:0] hidx_q;
	logic [PW-1:0] hs_q;
	logic [PW-1:0] hl_q;
	logic [3:0]    hk_q;
	ent_t          ins_q;
	ent_t          cur_q;
	logic [63:0]   addr_q;
	logic [CW-1:0] p_q;
	logic [CW-1:0] w_q;

	logic [64:0]   sum_end;
	logic [64:0]   sum_need;
	logic          range_ok;
	logic          bad_c;
	logic [XW-1:0] idx_ext;
	logic [XW-1:0] cnt_ext;
	logic [CW-1:0] im1;
	logic [PW-1:0] len;
	logic [PW-1:0] ns;
	logic          ovl;
	logic          cont;
	logic          join_c;
	logic          up_done;
	logic          sh_done;
	logic          exact;
	logic          pre;
	logic          post;
	logic [CW:0]   cnt_plus;
	logic          out_free;
	logic          res_op;

	assign sum_end  = {1'b0, in_item.base} + {1'b0, in_item.size};
	assign sum_need = {1'b0, in_item.size} + {1'b0, PG_MASK};
	assign range_ok = ((in_item.base & PG_MASK) == 64'd0) && ((in_item.size & PG_MASK) == 64'd0)
		&& (in_item.size != 64'd0) && !sum_end[64];
	assign idx_ext  = XW'(in_item.entry_index);
	assign cnt_ext  = XW'(count_q);

	always_comb begin
		case (in_item.func)
			FN_CREATE: bad_c = !range_ok;
			FN_ANY:    bad_c = (in_item.size == 64'd0) || (in_item.region_type == 4'd0)
				|| sum_need[64];
			FN_BASE:   bad_c = !range_ok || (in_item.region_type == 4'd0);
			default:   bad_c = idx_ext >= cnt_ext;
		endcase
	end

	assign im1     = i_q - CW'(1);
	assign len     = rd_q.l - rd_q.s;
	assign ns      = hl_q - need_q;
	assign ovl     = (s_q < rd_q.l) && (l_q > rd_q.s);
	assign cont    = (s_q >= rd_q.s) && (l_q <= rd_q.l);
	assign join_c  = (rd_q.s == cur_q.l) && (rd_q.k == cur_q.k);
	assign up_done = (i_q == count_q) && !pv_s1;
	assign sh_done = (i_q == p_q) && !pv_s1;
	assign exact   = (hl_q - hs_q) == need_q;
	assign pre     = hs_q < s_q;
	assign post    = hl_q > l_q;
	assign cnt_plus = {1'b0, count_q} + (CW+1)'(pre) + (CW+1)'(post);
	assign out_free = !out_valid_q || !out_stall;
	assign res_op  = (cmd.op == OP_RES_ERR) || (cmd.op == OP_RES_OK) || (cmd.op == OP_RES_READ);

	always_comb begin
		stat.func      = func_q;
		stat.bad       = bad_q;
		stat.up_hit    = pv_s1 && ((func_q == FN_CREATE) ? ovl : cont);
		stat.up_done   = up_done;
		stat.dn_hit    = pv_s1 && (rd_q.k == 4'd0) && (len >= need_q)
			&& ({rd_q.l, {PAGE_SHIFT{1'b0}}} < ceiling_q);
		stat.dn_done   = (i_q == CW'(0)) && !pv_s1;
		stat.find_hit  = pv_s1 && (rd_q.s > ins_q.s);
		stat.sh_done   = sh_done;
		stat.mg_done   = up_done;
		stat.kind_used = hk_q != 4'd0;
		stat.exact     = exact;
		stat.full1     = count_q == CW'(MAX_REGIONS);
		stat.full_base = cnt_plus > (CW+1)'(MAX_REGIONS);
		stat.pre       = pre;
		stat.post      = post;
		stat.out_free  = out_free;
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = i_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = w_q[IW-1:0];
		wr_data = cur_q;
		case (cmd.op)
			OP_UP_STEP, OP_FIND: begin
				rd_en = i_q < count_q;
			end
			OP_DN_STEP: begin
				rd_en   = i_q != CW'(0);
				rd_addr = im1[IW-1:0];
			end
			OP_SHIFT: begin
				rd_en   = i_q > p_q;
				rd_addr = im1[IW-1:0];
				wr_en   = pv_s1;
				wr_addr = pidx_s1 + IW'(1);
				wr_data = rd_q;
				if (sh_done) begin
					wr_en   = 1'b1;
					wr_addr = p_q[IW-1:0];
					wr_data = ins_q;
				end
			end
			OP_MERGE: begin
				rd_en = i_q < count_q;
				wr_en = (pv_s1 && !first_q && !join_c) || up_done;
			end
			OP_COMMIT: begin
				wr_addr = hidx_q;
				if (func_q == FN_ANY) begin
					wr_en   = 1'b1;
					wr_data = exact ? ent_t'{s: hs_q, l: hl_q, k: kind_q}
						: ent_t'{s: hs_q, l: ns, k: 4'd0};
				end else if (func_q == FN_BASE) begin
					wr_en   = 1'b1;
					wr_data = ent_t'{s: s_q, l: l_q, k: kind_q};
				end
			end
			OP_RD_IDX: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAP: begin
				func_q <= in_item.func;
				s_q    <= in_item.base[63:PAGE_SHIFT];
				l_q    <= sum_end[63:PAGE_SHIFT];
				need_q <= sum_need[63:PAGE_SHIFT];
				kind_q <= in_item.region_type;
				idx_q  <= idx_ext[IW-1:0];
				base_q <= in_item.base;
				bad_q  <= bad_c;
			end
			OP_UP_STEP: begin
				if (stat.up_hit) begin
					hidx_q <= pidx_s1;
					hs_q   <= rd_q.s;
					hl_q   <= rd_q.l;
					hk_q   <= rd_q.k;
				end
			end
			OP_DN_STEP: begin
				if (stat.dn_hit) begin
					hidx_q <= pidx_s1;
					hs_q   <= rd_q.s;
					hl_q   <= rd_q.l;
					hk_q   <= rd_q.k;
				end
			end
			OP_COMMIT: begin
				case (func_q)
					FN_ANY: begin
						ins_q  <= ent_t'{s: ns, l: hl_q, k: kind_q};
						addr_q <= exact ? {hs_q, {PAGE_SHIFT{1'b0}}} : {ns, {PAGE_SHIFT{1'b0}}};
					end
					FN_BASE: begin
						ins_q  <= pre ? ent_t'{s: hs_q, l: s_q, k: 4'd0}
							: ent_t'{s: l_q, l: hl_q, k: 4'd0};
						addr_q <= base_q;
					end
					default: begin
						ins_q  <= ent_t'{s: s_q, l: l_q, k: kind_q};
						addr_q <= base_q;
					end
				endcase
			end
			OP_INS_POST: ins_q <= ent_t'{s: l_q, l: hl_q, k: 4'd0};
			OP_FIND: begin
				if (stat.find_hit)
					p_q <= CW'(pidx_s1);
				else if (up_done)
					p_q <= count_q;
			end
			OP_SHIFT: begin
				if (sh_done)
					w_q <= '0;
			end
			OP_MERGE: begin
				if (pv_s1) begin
					if (first_q) begin
						cur_q <= rd_q;
					end else if (join_c) begin
						cur_q.l <= rd_q.l;
					end else begin
						cur_q <= rd_q;
						w_q   <= w_q + CW'(1);
					end
				end
			end
			OP_RES_ERR: out_q <= '{status: cmd.st, address: 64'd0, out_size: 64'd0, out_type: 4'd0};
			OP_RES_OK:  out_q <= '{status: ST_OK, address: addr_q, out_size: 64'd0, out_type: 4'd0};
			OP_RES_READ: begin
				out_q <= '{status: ST_OK, address: {rd_q.s, {PAGE_SHIFT{1'b0}}},
					out_size: {len, {PAGE_SHIFT{1'b0}}}, out_type: rd_q.k};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q   <= CEILING_RESET;
			count_q     <= '0;
			i_q         <= '0;
			pv_s1       <= 1'b0;
			pidx_s1     <= '0;
			first_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen)
				ceiling_q <= cfg_wdata;
			out_valid_q <= res_op || (out_valid_q && out_stall);
			case (cmd.op)
				OP_UP_INIT, OP_COMMIT, OP_INS_POST: begin
					i_q   <= '0;
					pv_s1 <= 1'b0;
				end
				OP_DN_INIT: begin
					i_q   <= count_q;
					pv_s1 <= 1'b0;
				end
				OP_UP_STEP, OP_FIND, OP_MERGE: begin
					if (i_q < count_q) begin
						i_q     <= i_q + CW'(1);
						pv_s1   <= 1'b1;
						pidx_s1 <= i_q[IW-1:0];
					end else begin
						pv_s1 <= 1'b0;
					end
					if (cmd.op == OP_FIND && (stat.find_hit || up_done)) begin
						i_q   <= count_q;
						pv_s1 <= 1'b0;
					end
					if (cmd.op == OP_MERGE) begin
						if (pv_s1)
							first_q <= 1'b0;
						if (up_done)
							count_q <= w_q + CW'(1);
					end
				end
				OP_DN_STEP: begin
					if (i_q != CW'(0)) begin
						i_q     <= im1;
						pv_s1   <= 1'b1;
						pidx_s1 <= im1[IW-1:0];
					end else begin
						pv_s1 <= 1'b0;
					end
				end
				OP_SHIFT: begin
					if (i_q > p_q) begin
						i_q     <= im1;
						pv_s1   <= 1'b1;
						pidx_s1 <= im1[IW-1:0];
					end else begin
						pv_s1 <= 1'b0;
					end
					if (sh_done) begin
						count_q <= count_q + CW'(1);
						i_q     <= '0;
						pv_s1   <= 1'b0;
						first_q <= 1'b1;
					end
				end
				default: begin
					pv_s1 <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_REGIONS))
		else $error("region count beyond table depth");
	a_res_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_op |-> out_free)
		else $error("result loaded over an undelivered item");
	a_pv_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		pv_s1 |-> $past(rd_en))
		else $error("pipeline data valid without a read");
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("table read and write at the same entry");

endmodule

// ===== rtl/pra_ctrl.sv =====
// Controller state machine for the physical region allocator.
// Depends on pra_pkg; sequences pra_datapath through commands and status.
module pra_ctrl import pra_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_UP,
		S_SCAN_DN,
		S_CHECK,
		S_FIND,
		S_SHIFT,
		S_MERGE,
		S_POST,
		S_FINISH
	} state_t;

	state_t state_q;
	op_t    res_q;
	st_t    st_q;
	logic   post_q;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		cmd = '{op: OP_NONE, st: ST_OK};
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					cmd.op = OP_CAP;
			end
			S_DISPATCH: begin
				if (!stat.bad) begin
					case (stat.func)
						FN_ANY:  cmd.op = OP_DN_INIT;
						FN_READ: cmd.op = OP_RD_IDX;
						default: cmd.op = OP_UP_INIT;
					endcase
				end
			end
			S_SCAN_UP: cmd.op = OP_UP_STEP;
			S_SCAN_DN: cmd.op = OP_DN_STEP;
			S_CHECK: begin
				case (stat.func)
					FN_CREATE: if (!stat.full1) cmd.op = OP_COMMIT;
					FN_ANY:    if (stat.exact || !stat.full1) cmd.op = OP_COMMIT;
					FN_BASE:   if (!stat.kind_used && !stat.full_base) cmd.op = OP_COMMIT;
					default:   cmd.op = OP_NONE;
				endcase
			end
			S_FIND:  cmd.op = OP_FIND;
			S_SHIFT: cmd.op = OP_SHIFT;
			S_MERGE: cmd.op = OP_MERGE;
			S_POST:  cmd.op = OP_INS_POST;
			S_FINISH: begin
				if (stat.out_free)
					cmd = '{op: res_q, st: st_q};
			end
			default: cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= OP_RES_ERR;
			st_q    <= ST_OK;
			post_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					if (stat.bad) begin
						res_q   <= OP_RES_ERR;
						st_q    <= ST_BADARG;
						state_q <= S_FINISH;
					end else begin
						case (stat.func)
							FN_ANY:  state_q <= S_SCAN_DN;
							FN_READ: begin
								res_q   <= OP_RES_READ;
								state_q <= S_FINISH;
							end
							default: state_q <= S_SCAN_UP;
						endcase
					end
				end
				S_SCAN_UP: begin
					if (stat.up_hit) begin
						if (stat.func == FN_CREATE) begin
							res_q   <= OP_RES_ERR;
							st_q    <= ST_OVERLAP;
							state_q <= S_FINISH;
						end else begin
							state_q <= S_CHECK;
						end
					end else if (stat.up_done) begin
						if (stat.func == FN_CREATE) begin
							state_q <= S_CHECK;
						end else begin
							res_q   <= OP_RES_ERR;
							st_q    <= ST_NOTFREE;
							state_q <= S_FINISH;
						end
					end
				end
				S_SCAN_DN: begin
					if (stat.dn_hit) begin
						state_q <= S_CHECK;
					end else if (stat.dn_done) begin
						res_q   <= OP_RES_ERR;
						st_q    <= ST_NOFIT;
						state_q <= S_FINISH;
					end
				end
				S_CHECK: begin
					res_q  <= OP_RES_OK;
					post_q <= 1'b0;
					case (stat.func)
						FN_CREATE: begin
							if (stat.full1) begin
								res_q   <= OP_RES_ERR;
								st_q    <= ST_FULL;
								state_q <= S_FINISH;
							end else begin
								state_q <= S_FIND;
							end
						end
						FN_ANY: begin
							if (stat.exact) begin
								state_q <= S_FINISH;
							end else if (stat.full1) begin
								res_q   <= OP_RES_ERR;
								st_q    <= ST_FULL;
								state_q <= S_FINISH;
							end else begin
								state_q <= S_FIND;
							end
						end
						FN_BASE: begin
							if (stat.kind_used) begin
								res_q   <= OP_RES_ERR;
								st_q    <= ST_NOTFREE;
								state_q <= S_FINISH;
							end else if (stat.full_base) begin
								res_q   <= OP_RES_ERR;
								st_q    <= ST_FULL;
								state_q <= S_FINISH;
							end else begin
								post_q  <= stat.pre && stat.post;
								state_q <= (stat.pre || stat.post) ? S_FIND : S_FINISH;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_FIND: begin
					if (stat.find_hit || stat.up_done)
						state_q <= S_SHIFT;
				end
				S_SHIFT: begin
					if (stat.sh_done)
						state_q <= S_MERGE;
				end
				S_MERGE: begin
					if (stat.mg_done) begin
						post_q  <= 1'b0;
						state_q <= post_q ? S_POST : S_FINISH;
					end
				end
				S_POST: state_q <= S_FIND;
				S_FINISH: begin
					if (stat.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && stat.out_free) |=> state_q == S_IDLE)
		else $error("finish did not return to idle");
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_CAP) |-> (state_q == S_IDLE))
		else $error("capture outside idle");
	a_post_base: assert property (@(posedge clk) disable iff (!arst_n)
		post_q |-> stat.func == FN_BASE)
		else $error("second split pending for non base request");

endmodule

// ===== rtl/physical_region_allocator_unit.sv =====
// Physical region allocator: a sorted table of typed page regions with create,
// allocate-anywhere, allocate-at-base and read requests, one result item per
// request item. Requests are served one at a time; the table is walked one entry
// per clock through its single read and single write port. A create or carving
// allocation runs the overlap or fit scan, the shift for the sorted insert, then
// the coalescing pass; an allocate-at-base that splits on both sides does the
// shift and the coalescing pass once per split. A new item is taken while the
// previous result still waits. The table needs no clearing after reset; write the
// ceiling only while no request is in flight.
module physical_region_allocator_unit import pra_pkg::*; #(
	parameter int MAX_REGIONS = 256,
	parameter int PAGE_SHIFT  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_wen,
	input  logic [63:0] cfg_wdata
);

	cmd_t  cmd;
	stat_t stat;

	pra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pra_datapath #(
		.MAX_REGIONS (MAX_REGIONS),
		.PAGE_SHIFT  (PAGE_SHIFT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== tb/physical_region_allocator_unit_checker.sv =====
// Checker for the physical region allocator: keeps its own copy of the region
// table and ceiling, predicts one result per accepted request and compares.
// Depends on pra_pkg for the item structs, function and status codes.
module physical_region_allocator_unit_checker import pra_pkg::*; #(
	parameter int MAX_REGIONS = 256,
	parameter int PAGE_SHIFT  = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_item_t    in_item,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_item_t   out_item,
	input  logic        cfg_wen,
	input  logic [63:0] cfg_wdata,
	output int          fail_count,
	output int          pending_results,
	output int          requests_seen,
	output int          results_seen
);

	localparam logic [63:0] PAGE_MASK = (64'd1 << PAGE_SHIFT) - 64'd1;

	logic [63:0] ceiling;
	logic [63:0] start_pg [MAX_REGIONS];
	logic [63:0] limit_pg [MAX_REGIONS];
	logic [3:0]  kind     [MAX_REGIONS];
	int          region_count;
	out_item_t   predicted_results [$];

	function automatic bit span_ok(logic [63:0] b, logic [63:0] s);
		return (b & PAGE_MASK) == 0 && (s & PAGE_MASK) == 0 && s != 0 && (b + s) > b;
	endfunction

	function automatic void coalesce_neighbors();
		int i;
		i = 0;
		while (i + 1 < region_count) begin
			if (start_pg[i + 1] == limit_pg[i] && kind[i + 1] == kind[i]) begin
				limit_pg[i] = limit_pg[i + 1];
				for (int j = i + 1; j + 1 < region_count; j++) begin
					start_pg[j] = start_pg[j + 1];
					limit_pg[j] = limit_pg[j + 1];
					kind[j] = kind[j + 1];
				end
				region_count--;
			end else begin
				i++;
			end
		end
	endfunction

	function automatic void place_region(logic [63:0] s, logic [63:0] l, logic [3:0] k);
		int p;
		p = 0;
		while (p < region_count && start_pg[p] <= s)
			p++;
		for (int j = region_count; j > p; j--) begin
			start_pg[j] = start_pg[j - 1];
			limit_pg[j] = limit_pg[j - 1];
			kind[j] = kind[j - 1];
		end
		start_pg[p] = s;
		limit_pg[p] = l;
		kind[p] = k;
		region_count++;
		coalesce_neighbors();
	endfunction

	function automatic out_item_t resolve_request(in_item_t it);
		out_item_t r;
		logic [63:0] s, l, need, rs, rl;
		int i, pieces;
		bit found;
		r = '0;
		r.status = ST_OK;
		found = 0;
		i = 0;
		case (it.func)
			FN_CREATE: begin
				if (!span_ok(it.base, it.size)) begin
					r.status = ST_BADARG;
				end else begin
					s = it.base >> PAGE_SHIFT;
					l = (it.base + it.size) >> PAGE_SHIFT;
					for (i = 0; i < region_count; i++)
						if (s < limit_pg[i] && l > start_pg[i])
							found = 1;
					if (found)
						r.status = ST_OVERLAP;
					else if (region_count >= MAX_REGIONS)
						r.status = ST_FULL;
					else begin
						place_region(s, l, it.region_type);
						r.address = it.base;
					end
				end
			end
			FN_ANY: begin
				if (it.size == 0 || it.region_type == 0 || it.size > ~PAGE_MASK) begin
					r.status = ST_BADARG;
				end else begin
					need = (it.size + PAGE_MASK) >> PAGE_SHIFT;
					i = region_count;
					while (i > 0 && !found) begin
						i--;
						if (kind[i] == 0 && limit_pg[i] - start_pg[i] >= need &&
						    (limit_pg[i] << PAGE_SHIFT) < ceiling)
							found = 1;
					end
					if (!found) begin
						r.status = ST_NOFIT;
					end else if (limit_pg[i] - start_pg[i] == need) begin
						kind[i] = it.region_type;
						r.address = start_pg[i] << PAGE_SHIFT;
					end else if (region_count >= MAX_REGIONS) begin
						r.status = ST_FULL;
					end else begin
						s = limit_pg[i] - need;
						l = limit_pg[i];
						limit_pg[i] = s;
						place_region(s, l, it.region_type);
						r.address = s << PAGE_SHIFT;
					end
				end
			end
			FN_BASE: begin
				if (!span_ok(it.base, it.size) || it.region_type == 0) begin
					r.status = ST_BADARG;
				end else begin
					s = it.base >> PAGE_SHIFT;
					l = (it.base + it.size) >> PAGE_SHIFT;
					for (i = 0; i < region_count && !found; i++)
						if (s >= start_pg[i] && l <= limit_pg[i])
							found = 1;
					if (found)
						i--;
					if (!found || kind[i] != 0) begin
						r.status = ST_NOTFREE;
					end else begin
						rs = start_pg[i];
						rl = limit_pg[i];
						pieces = (rs < s ? 1 : 0) + (rl > l ? 1 : 0);
						if (region_count + pieces > MAX_REGIONS) begin
							r.status = ST_FULL;
						end else begin
							start_pg[i] = s;
							limit_pg[i] = l;
							kind[i] = it.region_type;
							if (rs < s)
								place_region(rs, s, 4'd0);
							if (rl > l)
								place_region(l, rl, 4'd0);
							r.address = it.base;
						end
					end
				end
			end
			default: begin
				if (int'(it.entry_index) >= region_count) begin
					r.status = ST_BADARG;
				end else begin
					r.address = start_pg[it.entry_index] << PAGE_SHIFT;
					r.out_size = (limit_pg[it.entry_index] - start_pg[it.entry_index]) << PAGE_SHIFT;
					r.out_type = kind[it.entry_index];
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (!arst_n) begin
			ceiling = CEILING_RESET;
			region_count = 0;
			predicted_results.delete();
			fail_count <= 0;
			requests_seen <= 0;
			results_seen <= 0;
		end else begin
			if (cfg_wen)
				ceiling = cfg_wdata;
			if (in_valid && !in_stall) begin
				predicted_results.push_back(resolve_request(in_item));
				requests_seen <= requests_seen + 1;
			end
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				if (predicted_results.size() == 0) begin
					$error("unexpected result item: status %0d address %h",
						out_item.status, out_item.address);
					fail_count <= fail_count + 1;
				end else begin
					want = predicted_results.pop_front();
					if (out_item !== want) begin
						if (out_item.status !== want.status)
							$error("status: expected %0d, got %0d", want.status, out_item.status);
						if (out_item.address !== want.address)
							$error("address: expected %h, got %h", want.address, out_item.address);
						if (out_item.out_size !== want.out_size)
							$error("out_size: expected %h, got %h", want.out_size, out_item.out_size);
						if (out_item.out_type !== want.out_type)
							$error("out_type: expected %0d, got %0d", want.out_type, out_item.out_type);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
		pending_results <= predicted_results.size();
	end

endmodule

// ===== tb/physical_region_allocator_unit_test.sv =====
// Testbench top for the physical region allocator: clock, reset, request and
// ceiling stimulus, random idling on both channels, watchdog and verdict.
// Depends on pra_pkg, the block and physical_region_allocator_unit_checker.
module physical_region_allocator_unit_test import pra_pkg::*;;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 1400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_item;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_item;
	logic        cfg_wen;
	logic [63:0] cfg_wdata;

	int fail_count, pending_results, requests_seen, results_seen;
	int quiet_cycles = 0;
	int seen_results, rx_left, ceiling_writes;
	bit idle_on;

	physical_region_allocator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
	);

	physical_region_allocator_unit_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.fail_count(fail_count), .pending_results(pending_results),
		.requests_seen(requests_seen), .results_seen(results_seen)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int draw_gap();
		return idle_on ? $urandom_range(0, 18) : 0;
	endfunction

	initial begin
		out_stall = 0;
		seen_results = 0;
		rx_left = 0;
		forever begin
			@(negedge clk);
			if (results_seen != seen_results) begin
				seen_results = results_seen;
				rx_left = draw_gap();
			end
			if (out_valid && rx_left > 0) begin
				out_stall <= 1;
				rx_left--;
			end else begin
				out_stall <= 0;
			end
		end
	end

	task automatic send_request(func_t f, logic [63:0] b, logic [63:0] s,
	                            logic [3:0] t, logic [7:0] e);
		int gap, target;
		gap = draw_gap();
		repeat (gap) begin
			@(negedge clk);
			in_valid = 0;
		end
		@(negedge clk);
		in_valid = 1;
		in_item.func = f;
		in_item.base = b;
		in_item.size = s;
		in_item.region_type = t;
		in_item.entry_index = e;
		target = requests_seen + 1;
		wait (requests_seen == target);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic write_ceiling(logic [63:0] v);
		wait (pending_results == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wen = 1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_wen = 0;
		ceiling_writes++;
	endtask

	function automatic logic [63:0] wide_rand();
		return {$urandom, $urandom};
	endfunction

	task automatic random_request();
		int r;
		func_t f;
		logic [63:0] b, s;
		logic [3:0] t;
		logic [7:0] e;
		r = $urandom_range(0, 99);
		f = r < 30 ? FN_CREATE : r < 60 ? FN_ANY : r < 85 ? FN_BASE : FN_READ;
		r = $urandom_range(0, 99);
		b = r < 85 ? 64'($urandom_range(0, 255)) << 12 :
		    r < 95 ? wide_rand() : 64'($urandom_range(0, 1 << 20));
		r = $urandom_range(0, 99);
		if (f == FN_ANY)
			s = r < 80 ? 64'($urandom_range(1, 40000)) : r < 92 ? wide_rand() :
			    r < 96 ? 64'd0 : ~64'd0 - 64'($urandom_range(0, 8191));
		else
			s = r < 85 ? 64'($urandom_range(1, 12)) << 12 : r < 95 ? wide_rand() :
			    64'($urandom_range(0, 5000));
		r = $urandom_range(0, 99);
		t = (f == FN_CREATE && r < 50) || r < 5 ? 4'd0 : 4'($urandom_range(1, 15));
		e = $urandom_range(0, 99) < 80 ? 8'($urandom_range(0, 31)) : 8'($urandom);
		send_request(f, b, s, t, e);
	endtask

	initial begin
		arst_n = 0;
		in_valid = 0;
		in_item = '0;
		cfg_wen = 0;
		cfg_wdata = '0;
		idle_on = 0;
		ceiling_writes = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;

		send_request(FN_READ, 0, 0, 0, 0);
		send_request(FN_CREATE, 64'h1000_0800, 64'h1000, 0, 0);
		send_request(FN_CREATE, 64'h1000_0000, 0, 0, 0);
		send_request(FN_CREATE, 64'h1000_0000, 64'h1800, 0, 0);
		send_request(FN_CREATE, 64'hFFFF_FFFF_FFFF_F000, 64'h1000, 1, 0);
		send_request(FN_CREATE, 64'hFFFF_FFFF_FFFF_E000, 64'h1000, 15, 0);
		send_request(FN_CREATE, 64'h1000_0000, 64'h1_0000, 0, 0);
		send_request(FN_CREATE, 64'h1000_8000, 64'h1000, 2, 0);
		send_request(FN_CREATE, 64'h1001_0000, 64'h1_0000, 0, 0);
		send_request(FN_ANY, 0, 64'h1000, 0, 0);
		send_request(FN_ANY, 0, 0, 3, 0);
		send_request(FN_ANY, 0, 64'hFFFF_FFFF_FFFF_F001, 3, 0);
		send_request(FN_ANY, 0, 5000, 3, 0);
		send_request(FN_CREATE, 64'h2000_0000, 64'h3000, 0, 0);
		send_request(FN_ANY, 0, 64'h3000, 2, 0);
		send_request(FN_ANY, 0, 64'h100_0000_0000, 4, 0);
		send_request(FN_BASE, 64'h5000_0000, 64'h1000, 4, 0);
		send_request(FN_BASE, 64'h1000_4000, 64'h1000, 0, 0);
		send_request(FN_BASE, 64'h1000_4000, 64'h2000, 6, 0);
		send_request(FN_BASE, 64'h1000_4000, 64'h1000, 6, 0);
		send_request(FN_CREATE, 64'h3000_0000, 64'h2000, 0, 0);
		send_request(FN_BASE, 64'h3000_0000, 64'h2000, 9, 0);
		for (int i = 0; i < 4; i++)
			send_request(FN_READ, 0, 0, 0, 8'(i));
		send_request(FN_READ, 0, 0, 0, 8'd255);

		for (int i = 0; i < 130; i++) begin
			if (i % 40 == 0)
				idle_on = $urandom_range(0, 1);
			if (i % 30 == 0)
				case ((i / 30) % 5)
					0: write_ceiling(64'd0);
					1: write_ceiling(~64'd0);
					2: write_ceiling(64'($urandom_range(1, 256)) << 12);
					3: write_ceiling(wide_rand());
					default: write_ceiling(CEILING_RESET);
				endcase
			random_request();
		end

		write_ceiling(~64'd0);
		idle_on = 1;
		for (int i = 0; i < 270; i++) begin
			if (i % 50 == 0)
				idle_on = ~idle_on;
			send_request(FN_CREATE, 64'(4096 + 3 * i) << 12, 64'h2000, 4'(i % 2 ? 0 : 7), 0);
		end
		send_request(FN_ANY, 0, 64'h1000, 5, 0);
		send_request(FN_BASE, 64'(4096 + 3 * 269) << 12, 64'h1000, 5, 0);
		send_request(FN_ANY, 0, 64'h2000, 5, 0);
		send_request(FN_CREATE, 64'h7000_0000, 64'h1000, 1, 0);
		send_request(FN_READ, 0, 0, 0, 8'd255);
		send_request(FN_READ, 0, 0, 0, 8'd254);
		for (int i = 0; i < 20; i++)
			random_request();

		wait (pending_results == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("covered %0d requests and %0d results over %0d ceiling settings",
			requests_seen, results_seen, ceiling_writes + 1);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/pra_pkg.sv
rtl/pra_datapath.sv
rtl/pra_ctrl.sv
rtl/physical_region_allocator_unit.sv
tb/physical_region_allocator_unit_checker.sv
tb/physical_region_allocator_unit_test.sv
